// File: src/lrbgd_pkg.sv
// ============================================================================
// lrbgd_pkg
// Shared types, codes, defaults and saturation helpers for the batch
// gradient descent linear regression block.
// ============================================================================
package lrbgd_pkg;

    // Default sizes
    localparam int DEF_MAX_ROWS     = 512;
    localparam int DEF_MAX_FEATURES = 16;
    localparam int DEF_FRAC_BITS    = 16;

    // Field and register widths
    localparam int OPCODE_W = 3;
    localparam int ROW_W    = 9;
    localparam int COL_W    = 4;
    localparam int DATA_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int LR_W     = 17;
    localparam int ROWS_W   = 10;
    localparam int FEATS_W  = 5;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_LOAD_FEAT = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_LOAD_TGT  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_STEP      = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_READ      = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_RESTART   = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FEATS_IN_USE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MAX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MIN     = 3'd4;

    // Configuration reset values
    localparam logic [LR_W-1:0]           RST_LEARNING_RATE = 17'd655;
    localparam logic [ROWS_W-1:0]         RST_ROWS_IN_USE   = 10'd512;
    localparam logic [FEATS_W-1:0]        RST_FEATS_IN_USE  = 5'd13;
    localparam logic signed [DATA_W-1:0]  RST_SCALE_MAX     = 32'sd65536;
    localparam logic signed [DATA_W-1:0]  RST_SCALE_MIN     = 32'sd0;

    // Result kinds
    localparam logic KIND_COST   = 1'b0;
    localparam logic KIND_WEIGHT = 1'b1;

    typedef struct packed {
        logic               ovf;
        logic signed [31:0] val;
    } sat32_t;

    typedef struct packed {
        logic               ovf;
        logic signed [63:0] val;
    } sat64_t;

    // Clamp a wide signed value to 32 bits
    function automatic sat32_t sat32(input logic signed [65:0] x);
        sat32_t r;
        r.ovf = 1'b0;
        r.val = x[31:0];
        if (x > 66'sd2147483647) begin
            r.ovf = 1'b1;
            r.val = 32'sh7FFFFFFF;
        end else if (x < -66'sd2147483648) begin
            r.ovf = 1'b1;
            r.val = 32'sh80000000;
        end
        return r;
    endfunction

    // Saturating 64-bit add
    function automatic sat64_t add_sat64(input logic signed [63:0] a,
                                         input logic signed [63:0] b);
        sat64_t             r;
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        r.ovf = (s[64] != s[63]);
        if (r.ovf) begin
            r.val = s[64] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
        end else begin
            r.val = s[63:0];
        end
        return r;
    endfunction

endpackage

// File: src/linear_regression_batch_gd.sv
// ============================================================================
// linear_regression_batch_gd
// Batch gradient descent for linear regression in signed fixed point, with
// sample, target, residual and weight state held in on-chip memories.
// ============================================================================
// Sequencing: loads and restart finish in the idle state; a weight read passes
//   through the read and emit states; a step's length grows with R rows and
//   F features, set by the single multiply-accumulate path over the feature
//   memory and the serial divider by the row count.
// Throughput: one transaction at a time, taken once the last has left its result.
// Reset: synchronous, active low; clears control and weight valid bits and loads configuration defaults.
module linear_regression_batch_gd #(
    parameter int MAX_ROWS     = lrbgd_pkg::DEF_MAX_ROWS,
    parameter int MAX_FEATURES = lrbgd_pkg::DEF_MAX_FEATURES,
    parameter int FRAC_BITS    = lrbgd_pkg::DEF_FRAC_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [lrbgd_pkg::OPCODE_W-1:0]      s_opcode,
    input  logic [lrbgd_pkg::ROW_W-1:0]         s_row_index,
    input  logic [lrbgd_pkg::COL_W-1:0]         s_column_index,
    input  logic signed [lrbgd_pkg::DATA_W-1:0] s_data_value,
    // Result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [lrbgd_pkg::DATA_W-1:0] m_result_value,
    output logic                                m_result_kind,
    output logic [lrbgd_pkg::COL_W-1:0]         m_weight_index,
    output logic                                m_saturated,
    // Configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lrbgd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lrbgd_pkg::DATA_W-1:0]        cfg_data
);

    localparam int RW         = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int FW         = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int CW         = (RW > FW) ? RW : FW;
    localparam int FEAT_DEPTH = MAX_ROWS * MAX_FEATURES;
    localparam int AW         = (FEAT_DEPTH > 1) ? $clog2(FEAT_DEPTH) : 1;
    localparam int RCW        = $clog2(MAX_ROWS + 1);
    localparam int DIV_STEPS  = 64;
    localparam int DCW        = $clog2(DIV_STEPS);

    typedef enum logic [16:0] {
        ST_IDLE  = 17'h00001,
        ST_RD    = 17'h00002,
        ST_MAC   = 17'h00004,
        ST_DRAIN = 17'h00008,
        ST_FINP  = 17'h00010,
        ST_RWR   = 17'h00020,
        ST_ERR   = 17'h00040,
        ST_SQ    = 17'h00080,
        ST_CACC  = 17'h00100,
        ST_DIVS  = 17'h00200,
        ST_DIV   = 17'h00400,
        ST_DIVE  = 17'h00800,
        ST_GMUL  = 17'h01000,
        ST_WUPD  = 17'h02000,
        ST_CMUL  = 17'h04000,
        ST_COUT  = 17'h08000,
        ST_EMIT  = 17'h10000
    } state_t;

    typedef enum logic [2:0] {
        PASS_RES  = 3'b001,
        PASS_GRAD = 3'b010,
        PASS_COST = 3'b100
    } pass_t;

    // Memories
    logic signed [31:0] feat_mem [FEAT_DEPTH];
    logic signed [31:0] tgt_mem  [MAX_ROWS];
    logic signed [31:0] res_mem  [MAX_ROWS];
    logic signed [31:0] wgt_mem  [MAX_FEATURES];

    // Configuration
    logic [lrbgd_pkg::LR_W-1:0]    learning_rate_reg;
    logic [lrbgd_pkg::ROWS_W-1:0]  rows_in_use_reg;
    logic [lrbgd_pkg::FEATS_W-1:0] feats_in_use_reg;
    logic signed [31:0]            scale_max_reg;
    logic signed [31:0]            scale_min_reg;

    // Control
    state_t             state_reg, state_next;
    pass_t              pass_reg;
    logic [CW-1:0]      oc_reg;
    logic [CW-1:0]      ic_reg;
    logic               data_v_reg;
    logic               prod_v_reg;
    logic [MAX_FEATURES-1:0] wvalid_reg;
    logic               sat_reg;

    // Memory read data
    logic signed [31:0] f_q, t_q, r_q, w_q;
    logic               wv_q;

    // Datapath
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] cacc_reg;
    logic signed [31:0] p_reg;
    logic signed [31:0] e_reg;
    logic signed [63:0] sq_reg;
    logic [63:0]        dq_reg;
    logic [RCW-1:0]     rem_reg;
    logic [DCW-1:0]     dcnt_reg;
    logic               dneg_reg;
    logic signed [31:0] g_reg;
    logic signed [49:0] lrg_reg;
    logic signed [31:0] cost_reg;
    logic signed [64:0] cd_reg;
    logic signed [31:0] res_val_reg;
    logic               res_kind_reg;
    logic [lrbgd_pkg::COL_W-1:0] col_reg;
    logic               rd_ok_reg;
    logic               o_satf_reg;

    // Output register
    logic               m_valid_reg;
    logic signed [31:0] m_value_reg;
    logic               m_kind_reg;
    logic [lrbgd_pkg::COL_W-1:0] m_idx_reg;
    logic               m_sat_reg;

    // Combinational
    logic [31:0]        nr32, nf32;
    logic [CW-1:0]      nr_m1, nf_m1, last_ic;
    logic [RCW-1:0]     divisor;
    logic [CW-1:0]      frow, fcol;
    logic [AW-1:0]      feat_raddr, feat_waddr;
    logic [FW-1:0]      w_raddr;
    logic               s_accept, feat_ok, tgt_ok, row_last, emit_go;
    logic signed [31:0] opb, w_old;
    logic signed [63:0] div_num;
    logic [RCW:0]       rem_sh;
    logic               q_bit;
    logic signed [64:0] quo;
    lrbgd_pkg::sat64_t  acc_add, c_add;
    lrbgd_pkg::sat32_t  p_sat, r_sat, e_sat, q_sat, u_sat, o_sat;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign emit_go   = !m_valid_reg || m_ready;

    // Clamp the row and feature counts to the store sizes, raising zero to one
    always_comb begin
        nr32 = 32'(rows_in_use_reg);
        if (nr32 == 32'd0) begin
            nr32 = 32'd1;
        end else if (nr32 > 32'(MAX_ROWS)) begin
            nr32 = 32'(MAX_ROWS);
        end
        nf32 = 32'(feats_in_use_reg);
        if (nf32 == 32'd0) begin
            nf32 = 32'd1;
        end else if (nf32 > 32'(MAX_FEATURES)) begin
            nf32 = 32'(MAX_FEATURES);
        end
    end

    assign nr_m1    = CW'(nr32 - 32'd1);
    assign nf_m1    = CW'(nf32 - 32'd1);
    assign divisor  = RCW'(nr32);
    assign last_ic  = (pass_reg == PASS_GRAD) ? nr_m1 : nf_m1;
    assign row_last = (oc_reg == nr_m1);

    // Address generation: gradient pass walks rows inside each column
    assign frow = (pass_reg == PASS_GRAD) ? ic_reg : oc_reg;
    assign fcol = (pass_reg == PASS_GRAD) ? oc_reg : ic_reg;
    assign feat_raddr = AW'(32'(frow) * 32'(MAX_FEATURES) + 32'(fcol));
    assign feat_waddr = AW'(32'(s_row_index) * 32'(MAX_FEATURES) + 32'(s_column_index));
    assign feat_ok = (32'(s_row_index) < 32'(MAX_ROWS))
                  && (32'(s_column_index) < 32'(MAX_FEATURES));
    assign tgt_ok  = (32'(s_row_index) < 32'(MAX_ROWS));

    always_comb begin
        if (state_reg == ST_IDLE) begin
            w_raddr = FW'(s_column_index);
        end else if (pass_reg == PASS_GRAD) begin
            w_raddr = FW'(oc_reg);
        end else begin
            w_raddr = FW'(ic_reg);
        end
    end

    // Arithmetic
    assign w_old   = wv_q ? w_q : 32'sd0;
    assign opb     = (pass_reg == PASS_GRAD) ? r_q : w_old;
    assign acc_add = lrbgd_pkg::add_sat64(acc_reg, prod_reg);
    assign c_add   = lrbgd_pkg::add_sat64(cacc_reg, sq_reg);
    assign p_sat   = lrbgd_pkg::sat32(66'(acc_reg >>> FRAC_BITS));
    assign r_sat   = lrbgd_pkg::sat32(66'(p_reg) - 66'(t_q));
    assign e_sat   = lrbgd_pkg::sat32(66'(t_q) - 66'(p_reg));
    assign div_num = (pass_reg == PASS_GRAD) ? (acc_reg >>> FRAC_BITS)
                                             : (cacc_reg >>> FRAC_BITS);
    assign rem_sh  = {rem_reg, dq_reg[63]};
    assign q_bit   = (rem_sh >= {1'b0, divisor});
    assign quo     = dneg_reg ? -$signed({1'b0, dq_reg}) : $signed({1'b0, dq_reg});
    assign q_sat   = lrbgd_pkg::sat32(66'(quo));
    assign u_sat   = lrbgd_pkg::sat32(66'(w_old) - 66'(lrg_reg >>> FRAC_BITS));
    assign o_sat   = lrbgd_pkg::sat32(66'(cd_reg >>> FRAC_BITS) + 66'(scale_min_reg));

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && s_opcode == lrbgd_pkg::OP_STEP) begin
                    state_next = ST_MAC;
                end else if (s_accept && s_opcode == lrbgd_pkg::OP_READ) begin
                    state_next = ST_RD;
                end
            end
            ST_RD:    state_next = ST_EMIT;
            ST_MAC: begin
                if (ic_reg == last_ic) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!data_v_reg && !prod_v_reg) begin
                    state_next = (pass_reg == PASS_GRAD) ? ST_DIVS : ST_FINP;
                end
            end
            ST_FINP:  state_next = (pass_reg == PASS_RES) ? ST_RWR : ST_ERR;
            ST_RWR:   state_next = ST_MAC;
            ST_ERR:   state_next = ST_SQ;
            ST_SQ:    state_next = ST_CACC;
            ST_CACC:  state_next = row_last ? ST_DIVS : ST_MAC;
            ST_DIVS:  state_next = ST_DIV;
            ST_DIV: begin
                if (dcnt_reg == DCW'(DIV_STEPS - 1)) begin
                    state_next = ST_DIVE;
                end
            end
            ST_DIVE:  state_next = (pass_reg == PASS_GRAD) ? ST_GMUL : ST_CMUL;
            ST_GMUL:  state_next = ST_WUPD;
            ST_WUPD:  state_next = ST_MAC;
            ST_CMUL:  state_next = ST_COUT;
            ST_COUT:  state_next = ST_EMIT;
            ST_EMIT: begin
                if (emit_go) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Feature and target memories: load writes, pass reads
    always_ff @(posedge aclk) begin
        if (s_accept && s_opcode == lrbgd_pkg::OP_LOAD_FEAT && feat_ok) begin
            feat_mem[feat_waddr] <= s_data_value;
        end
        f_q <= feat_mem[feat_raddr];
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_opcode == lrbgd_pkg::OP_LOAD_TGT && tgt_ok) begin
            tgt_mem[RW'(s_row_index)] <= s_data_value;
        end
        t_q <= tgt_mem[RW'(oc_reg)];
    end

    // Residual memory: written in the residual pass, read in the gradient pass
    always_ff @(posedge aclk) begin
        if (state_reg == ST_RWR) begin
            res_mem[RW'(oc_reg)] <= r_sat.val;
        end
        r_q <= res_mem[RW'(ic_reg)];
    end

    // Weight memory: written back after each column update
    always_ff @(posedge aclk) begin
        if (state_reg == ST_WUPD) begin
            wgt_mem[FW'(oc_reg)] <= u_sat.val;
        end
        w_q  <= wgt_mem[w_raddr];
        wv_q <= wvalid_reg[w_raddr];
    end

    // Control state, configuration and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            pass_reg          <= PASS_RES;
            oc_reg            <= '0;
            ic_reg            <= '0;
            data_v_reg        <= 1'b0;
            prod_v_reg        <= 1'b0;
            wvalid_reg        <= '0;
            sat_reg           <= 1'b0;
            dcnt_reg          <= '0;
            m_valid_reg       <= 1'b0;
            learning_rate_reg <= lrbgd_pkg::RST_LEARNING_RATE;
            rows_in_use_reg   <= lrbgd_pkg::RST_ROWS_IN_USE;
            feats_in_use_reg  <= lrbgd_pkg::RST_FEATS_IN_USE;
            scale_max_reg     <= lrbgd_pkg::RST_SCALE_MAX;
            scale_min_reg     <= lrbgd_pkg::RST_SCALE_MIN;
        end else begin
            state_reg  <= state_next;
            data_v_reg <= (state_reg == ST_MAC);
            prod_v_reg <= data_v_reg;

            // Write configuration registers
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    lrbgd_pkg::CFG_LEARNING_RATE:
                        learning_rate_reg <= cfg_data[lrbgd_pkg::LR_W-1:0];
                    lrbgd_pkg::CFG_ROWS_IN_USE:
                        rows_in_use_reg <= cfg_data[lrbgd_pkg::ROWS_W-1:0];
                    lrbgd_pkg::CFG_FEATS_IN_USE:
                        feats_in_use_reg <= cfg_data[lrbgd_pkg::FEATS_W-1:0];
                    lrbgd_pkg::CFG_SCALE_MAX: scale_max_reg <= $signed(cfg_data);
                    lrbgd_pkg::CFG_SCALE_MIN: scale_min_reg <= $signed(cfg_data);
                    default: ;
                endcase
            end

            // Start a transaction
            if (s_accept) begin
                case (s_opcode)
                    lrbgd_pkg::OP_STEP: begin
                        pass_reg <= PASS_RES;
                        oc_reg   <= '0;
                        sat_reg  <= 1'b0;
                    end
                    lrbgd_pkg::OP_RESTART: wvalid_reg <= '0;
                    default: ;
                endcase
            end

            // Advance the inner counter; restart it on entry to a dot product
            if (state_reg == ST_MAC) begin
                ic_reg <= ic_reg + 1'b1;
            end
            if (state_next == ST_MAC && state_reg != ST_MAC) begin
                ic_reg <= '0;
            end

            // Accumulate saturation
            if (prod_v_reg && acc_add.ovf) sat_reg <= 1'b1;
            if (state_reg == ST_FINP && p_sat.ovf) sat_reg <= 1'b1;
            if (state_reg == ST_RWR && r_sat.ovf) sat_reg <= 1'b1;
            if (state_reg == ST_ERR && e_sat.ovf) sat_reg <= 1'b1;
            if (state_reg == ST_CACC && c_add.ovf) sat_reg <= 1'b1;
            if (state_reg == ST_DIVE && q_sat.ovf) sat_reg <= 1'b1;
            if (state_reg == ST_WUPD && u_sat.ovf) sat_reg <= 1'b1;

            // Advance the outer counter and the pass
            if (state_reg == ST_RWR) begin
                if (row_last) begin
                    oc_reg   <= '0;
                    pass_reg <= PASS_GRAD;
                end else begin
                    oc_reg <= oc_reg + 1'b1;
                end
            end
            if (state_reg == ST_CACC) begin
                oc_reg <= oc_reg + 1'b1;
            end
            if (state_reg == ST_WUPD) begin
                wvalid_reg[FW'(oc_reg)] <= 1'b1;
                if (oc_reg == nf_m1) begin
                    oc_reg   <= '0;
                    pass_reg <= PASS_COST;
                end else begin
                    oc_reg <= oc_reg + 1'b1;
                end
            end

            // Divider step count
            if (state_reg == ST_DIVS) begin
                dcnt_reg <= '0;
            end else if (state_reg == ST_DIV) begin
                dcnt_reg <= dcnt_reg + 1'b1;
            end

            // Hold or release the output register
            if (state_reg == ST_EMIT && emit_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        prod_reg <= f_q * opb;

        // Dot product accumulator
        if (prod_v_reg) begin
            acc_reg <= acc_add.val;
        end else if (state_next == ST_MAC && state_reg != ST_MAC) begin
            acc_reg <= '0;
        end

        // Cost accumulator
        if (state_reg == ST_WUPD && oc_reg == nf_m1) begin
            cacc_reg <= '0;
        end else if (state_reg == ST_CACC) begin
            cacc_reg <= c_add.val;
        end

        if (state_reg == ST_FINP) p_reg <= p_sat.val;
        if (state_reg == ST_ERR)  e_reg <= e_sat.val;
        if (state_reg == ST_SQ)   sq_reg <= e_reg * e_reg;

        // Restoring divider by the row count, one quotient bit a cycle
        if (state_reg == ST_DIVS) begin
            dneg_reg <= div_num[63];
            dq_reg   <= div_num[63] ? 64'(-div_num) : 64'(div_num);
            rem_reg  <= '0;
        end else if (state_reg == ST_DIV) begin
            dq_reg  <= {dq_reg[62:0], q_bit};
            rem_reg <= q_bit ? RCW'(rem_sh - {1'b0, divisor}) : RCW'(rem_sh);
        end
        if (state_reg == ST_DIVE) begin
            g_reg    <= q_sat.val;
            cost_reg <= q_sat.val;
        end

        if (state_reg == ST_GMUL) begin
            lrg_reg <= $signed({1'b0, learning_rate_reg}) * g_reg;
        end
        if (state_reg == ST_CMUL) begin
            cd_reg <= cost_reg * (33'(scale_max_reg) - 33'(scale_min_reg));
        end

        // Capture the weight read request
        if (s_accept) begin
            col_reg   <= s_column_index;
            rd_ok_reg <= (32'(s_column_index) < 32'(MAX_FEATURES));
        end

        // Stage the result
        if (state_reg == ST_RD) begin
            res_val_reg  <= rd_ok_reg ? w_old : 32'sd0;
            res_kind_reg <= lrbgd_pkg::KIND_WEIGHT;
        end else if (state_reg == ST_COUT) begin
            res_val_reg  <= o_sat.val;
            res_kind_reg <= lrbgd_pkg::KIND_COST;
        end

        if (state_reg == ST_EMIT && emit_go) begin
            m_value_reg <= res_val_reg;
            m_kind_reg  <= res_kind_reg;
            m_idx_reg   <= (res_kind_reg == lrbgd_pkg::KIND_WEIGHT) ? col_reg : '0;
            m_sat_reg   <= (res_kind_reg == lrbgd_pkg::KIND_WEIGHT) ? 1'b0
                                                                     : (sat_reg | o_satf_reg);
        end
    end

    // Saturation of the final rescale, registered alongside the staged cost result
    always_ff @(posedge aclk) begin
        if (state_reg == ST_COUT) begin
            o_satf_reg <= o_sat.ovf;
        end else if (state_reg == ST_RD) begin
            o_satf_reg <= 1'b0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_value_reg;
    assign m_result_kind  = m_kind_reg;
    assign m_weight_index = m_idx_reg;
    assign m_saturated    = m_sat_reg;

endmodule

// File: src/lrbgd_checker.sv
// ============================================================================
// lrbgd_checker
// Port-level checks for the batch gradient descent block, bound to the top.
// ============================================================================
module lrbgd_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [lrbgd_pkg::DATA_W-1:0] m_result_value,
    input logic                                m_result_kind,
    input logic [lrbgd_pkg::COL_W-1:0]         m_weight_index,
    input logic                                m_saturated
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value))
        else $error("result changed while stalled");

    // An offered input transaction stays offered until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input valid dropped before acceptance");

    // A weight read never reports saturation
    a_read_nosat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == lrbgd_pkg::KIND_WEIGHT |-> !m_saturated)
        else $error("weight read flagged saturated");

    // A cost result carries index zero
    a_cost_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == lrbgd_pkg::KIND_COST |-> m_weight_index == '0)
        else $error("cost result with nonzero index");

    // Reset drops the result valid
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind linear_regression_batch_gd lrbgd_checker u_lrbgd_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_result_value (m_result_value),
    .m_result_kind  (m_result_kind),
    .m_weight_index (m_weight_index),
    .m_saturated    (m_saturated)
);
